/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on a clock with an active-low reset, off in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define SACT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");
// expression must never be true outside reset
`define SACT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");
`else
`define SACT_ASSERT(lbl, clk, rstn, prop)
`define SACT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* hdl/sactag_pkg.sv */
// ----------------------------------------------------------------------------
// sactag_pkg
// shared constants and helpers for the set-associative cache tag store
// ----------------------------------------------------------------------------
package sactag_pkg;

	localparam int ADDR_W          = 32;
	localparam int SEED_W          = 16;
	localparam int CNT_W           = 32;
	localparam int WAY_OUT_W       = 2;

	localparam int LINE_BYTES_DEF  = 64;
	localparam int SET_COUNT_DEF   = 256;
	localparam int WAYS_DEF        = 4;

	localparam logic [SEED_W-1:0] SEED_RESET = 16'hACE1;
	localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

	// fibonacci lfsr, taps 16 14 13 11, shifts right
	function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] r);
		logic fb;
		fb = r[0] ^ r[2] ^ r[3] ^ r[5];
		return {fb, r[SEED_W-1:1]};
	endfunction

	// saturating increment
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == CNT_MAX) ? c : c + CNT_W'(1);
	endfunction

endpackage

/* hdl/set_associative_cache_tags_core.sv */
// ----------------------------------------------------------------------------
// set_associative_cache_tags_core
// tag store of an n-way set-associative cache with lfsr random replacement
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                    word contents (low bit up)
// s_axis    in         s_axis_tvalid/s_axis_tready  access_address[31:0]
// m_axis    out        m_axis_tvalid/m_axis_tready  is_hit, way_used[1:0],
//                                                   evicted_valid, hit_total,
//                                                   miss_total, 4 zero bits
// cfg       in         cfg_wr_en (no wait)          lfsr_seed[15:0]
//
// one word per cycle sustained while m_axis_tready is high; a word passes the lookup stage
// (set row read from the tag memory) and then sits in the output register
// a miss writes the updated row back in the cycle the word leaves the lookup
// stage; a read of the same row in that cycle is forwarded from the write
// after reset a clearing pass zeroes the tag memory, one set row per cycle;
// s_axis_tready stays low until it is done
// the lookup stage holds while the output register is full and not taken;
// s_axis_tready then drops
//
module set_associative_cache_tags_core #(
	parameter int LINE_BYTES = sactag_pkg::LINE_BYTES_DEF,
	parameter int SET_COUNT  = sactag_pkg::SET_COUNT_DEF,
	parameter int WAYS       = sactag_pkg::WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: lfsr_seed[15:0]
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// access_address[31:0]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	// is_hit[0], way_used[2:1], evicted_valid[3], hit_total[35:4],
	// miss_total[67:36], zero fill[71:68]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata
);

	`include "assert_macros.svh"

	// address split
	localparam int OFF_W  = $clog2(LINE_BYTES);
	localparam int SET_W  = $clog2(SET_COUNT);
	localparam int IDX_W  = (SET_W > 0) ? SET_W : 1;
	localparam int TAG_W  = sactag_pkg::ADDR_W - OFF_W - SET_W;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	// one way entry in a row: {valid, tag}
	localparam int ENT_W  = TAG_W + 1;
	localparam int ROW_W  = WAYS * ENT_W;
	localparam int CNT_W  = sactag_pkg::CNT_W;
	localparam int SEED_W = sactag_pkg::SEED_W;

	// ---------------------------------------------------------------- control
	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             adv;
	logic             in_acc;

	// stage is free when empty or when its word moves on this cycle
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !clr_busy_q && (!valid_s1 || adv);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// input address split
	logic [sactag_pkg::ADDR_W-1:0] blk_in;
	logic [IDX_W-1:0]              set_in;
	logic [TAG_W-1:0]              tag_in;

	assign blk_in = s_axis_tdata >> OFF_W;
	assign set_in = IDX_W'(blk_in) & IDX_W'(SET_COUNT - 1);
	assign tag_in = TAG_W'(blk_in >> SET_W);

	// ---------------------------------------------------------------- tag memory
	logic [ROW_W-1:0] tag_mem [SET_COUNT];
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ROW_W-1:0] mem_wdata;
	logic [ROW_W-1:0] row_s1;
	logic [ROW_W-1:0] new_row;
	logic             hit;
	logic             free;
	logic [IDX_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;

	// clearing pass has the write port to itself
	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
			mem_wdata = '0;
		end else begin
			mem_we    = adv && !hit;
			mem_waddr = set_s1;
			mem_wdata = new_row;
		end
	end

	// registered read, forwarded when the row is written in the same cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[mem_waddr] <= mem_wdata;
		end
		if (in_acc) begin
			if (mem_we && (mem_waddr == set_in)) begin
				row_s1 <= mem_wdata;
			end else begin
				row_s1 <= tag_mem[set_in];
			end
		end
	end

	// ---------------------------------------------------------------- lookup stage
	always_ff @(posedge clk) begin
		if (in_acc) begin
			set_s1 <= set_in;
			tag_s1 <= tag_in;
		end
	end

	// random way = lfsr value mod WAYS, from byte residue tables
	logic [SEED_W-1:0] rand_q;
	logic [WAY_W-1:0]  lo_tab [256];
	logic [WAY_W-1:0]  hi_tab [256];
	logic [WAY_W:0]    rand_sum;
	logic [WAY_W-1:0]  rand_way;

	for (genvar g = 0; g < 256; g++) begin : g_mod_tab
		assign lo_tab[g] = WAY_W'(g % WAYS);
		assign hi_tab[g] = WAY_W'((g * 256) % WAYS);
	end

	// both residues are below WAYS, so one subtract folds the sum
	assign rand_sum = {1'b0, lo_tab[rand_q[7:0]]} + {1'b0, hi_tab[rand_q[15:8]]};
	assign rand_way = (rand_sum >= (WAY_W + 1)'(WAYS)) ?
		WAY_W'(rand_sum - (WAY_W + 1)'(WAYS)) : WAY_W'(rand_sum);

	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic [WAY_W-1:0] fill_way;
	logic [WAY_W-1:0] way_sel;

	// lowest matching way and lowest invalid way
	always_comb begin
		hit      = 1'b0;
		hit_way  = '0;
		free     = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (row_s1[w*ENT_W + TAG_W] && (row_s1[w*ENT_W +: TAG_W] == tag_s1)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!row_s1[w*ENT_W + TAG_W]) begin
				free     = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	assign fill_way = free ? free_way : rand_way;
	assign way_sel  = hit ? hit_way : fill_way;

	// row with the filled way replaced
	always_comb begin
		new_row = row_s1;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == fill_way) begin
				new_row[w*ENT_W +: ENT_W] = {1'b1, tag_s1};
			end
		end
	end

	// ---------------------------------------------------------------- counters
	logic [CNT_W-1:0] hit_cnt_q;
	logic [CNT_W-1:0] miss_cnt_q;
	logic [CNT_W-1:0] hit_cnt_nxt;
	logic [CNT_W-1:0] miss_cnt_nxt;

	assign hit_cnt_nxt  = hit ? sactag_pkg::sat_inc(hit_cnt_q) : hit_cnt_q;
	assign miss_cnt_nxt = hit ? miss_cnt_q : sactag_pkg::sat_inc(miss_cnt_q);

	// ---------------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			rand_q      <= sactag_pkg::SEED_RESET;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
				if (clr_idx_q == IDX_W'(SET_COUNT - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			// a zero seed would lock the lfsr, so it loads the reset seed
			if (cfg_wr_en) begin
				rand_q <= (cfg_wr_data == '0) ? sactag_pkg::SEED_RESET : cfg_wr_data;
			end else if (adv && !hit && !free) begin
				rand_q <= sactag_pkg::lfsr_next(rand_q);
			end
			if (adv) begin
				hit_cnt_q  <= hit_cnt_nxt;
				miss_cnt_q <= miss_cnt_nxt;
			end
		end
	end

	// ---------------------------------------------------------------- output register
	logic                             hit_q;
	logic [sactag_pkg::WAY_OUT_W-1:0] way_q;
	logic                             evict_q;
	logic [CNT_W-1:0]                 hit_tot_q;
	logic [CNT_W-1:0]                 miss_tot_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q      <= hit;
			way_q      <= sactag_pkg::WAY_OUT_W'(way_sel);
			evict_q    <= !hit && !free;
			hit_tot_q  <= hit_cnt_nxt;
			miss_tot_q <= miss_cnt_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, miss_tot_q, hit_tot_q, evict_q, way_q, hit_q};

	// ---------------------------------------------------------------- checks
	`SACT_NEVER(a_no_take_in_clear, clk, arst_n, clr_busy_q && s_axis_tready)
	`SACT_NEVER(a_rand_nonzero, clk, arst_n, rand_q == '0)
	`SACT_ASSERT(a_hit_count, clk, arst_n, adv && hit && (hit_cnt_q != sactag_pkg::CNT_MAX) |=> hit_cnt_q == $past(hit_cnt_q) + CNT_W'(1))
	`SACT_ASSERT(a_evict_steps_lfsr, clk, arst_n, adv && !hit && !free && !cfg_wr_en |=> rand_q != $past(rand_q))

endmodule
